// ===== rtl/core/alms_pkg.sv =====
// Shared definitions for the acceleration-limited motion step.
// Register indexes, reset values, op codes and Q16.16 helpers.
// No dependencies.
`timescale 1ns / 1ps

package alms_pkg;

  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int SAT_W     = 96;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_ACCEL_LIMIT = 2'd0;
  localparam cfg_idx_t CFG_STEP_PERIOD = 2'd1;
  localparam cfg_idx_t CFG_TICK_TIME   = 2'd2;

  localparam logic [CFG_W-1:0] ACCEL_LIMIT_RST = 31'd262144000;
  localparam logic [CFG_W-1:0] STEP_PERIOD_RST = 31'd1092;
  localparam logic [CFG_W-1:0] TICK_TIME_RST   = 31'd1092;

  localparam logic OP_CMD_VEL = 1'b0;
  localparam logic OP_ACCEL   = 1'b1;

  localparam logic signed [SAT_W-1:0] MAX32 = {{(SAT_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SAT_W-1:0] MIN32 = {{(SAT_W-31){1'b1}}, {31{1'b0}}};

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [31:0] r;
    if (x > MAX32) begin
      r = MAX32[31:0];
    end else if (x < MIN32) begin
      r = MIN32[31:0];
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic signed [31:0] n;
    n = -v;
    return v[31] ? 32'(n) : 32'(v);
  endfunction

endpackage

// ===== rtl/core/accel_limited_motion_step.sv =====
// Acceleration-limited motion step: fully pipelined top level.
// Depends on alms_pkg.
`timescale 1ns / 1ps

// One beat in, one beat out, every cycle unless the result side stalls; the pipeline is built
// around three bit-serial chains laid out as stages, with Q16.16 as the default format:
// the command divider (32+FRAC_BITS stages, one quotient bit each), the 32-stage square root
// of the normalized norm and the 32-stage division that rescales the capped vector. A stall on
// the result side holds the whole pipeline and is passed back on in_stall_o in the same cycle.
// Registers are sampled as the pipeline runs, so write them only while no beat is in flight.
module accel_limited_motion_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic signed [31:0]              pos_x_i,
  input  logic signed [31:0]              pos_y_i,
  input  logic signed [31:0]              vel_x_i,
  input  logic signed [31:0]              vel_y_i,
  input  logic signed [31:0]              target_x_i,
  input  logic signed [31:0]              target_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [31:0]              end_pos_x_o,
  output logic signed [31:0]              end_pos_y_o,
  output logic signed [31:0]              end_vel_x_o,
  output logic signed [31:0]              end_vel_y_o,
  output logic signed [31:0]              accel_x_o,
  output logic signed [31:0]              accel_y_o,
  output logic                            was_capped_o,
  input  logic                            cfg_we_i,
  input  logic [alms_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [alms_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import alms_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int NW    = 32 + F;
  localparam int NL    = $clog2(NW);
  localparam int QW    = 63 - F;
  localparam int QL    = QW / 2;
  localparam int QH    = QW - QL;
  localparam int PW    = QW + 31;
  localparam int RVW   = 64 - F;
  localparam int RW    = PW - F + 1;
  localparam int EPS_Q = ((1 << F) + 50) / 100;

  localparam int I_IN    = 0;
  localparam int I_DIV0  = I_IN + 1;
  localparam int I_SQ    = I_DIV0 + NW;
  localparam int I_CMP   = I_SQ + 1;
  localparam int I_NRM0  = I_CMP + 1;
  localparam int I_NSQ   = I_NRM0 + NL;
  localparam int I_SUM   = I_NSQ + 1;
  localparam int I_SQRT0 = I_SUM + 1;
  localparam int I_QDIV0 = I_SQRT0 + 32;
  localparam int I_SEL   = I_QDIV0 + 32;
  localparam int I_MT    = I_SEL + 1;
  localparam int I_VR    = I_MT + 1;
  localparam int I_WM    = I_VR + 1;
  localparam int I_WC    = I_WM + 1;
  localparam int I_OUT   = I_WC + 1;
  localparam int NS      = I_OUT + 1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               sx;
    logic               sy;
    logic [NW-1:0]      ux;
    logic [NW-1:0]      uy;
    logic [NW-1:0]      nx;
    logic [NW-1:0]      ny;
    logic [31:0]        rx;
    logic [31:0]        ry;
    logic [61:0]        sqx;
    logic [61:0]        sqy;
    logic [61:0]        limsq;
    logic               big;
    logic               capped;
    logic signed [31:0] arx;
    logic signed [31:0] ary;
    logic [61:0]        pmx;
    logic [61:0]        pmy;
    logic [64:0]        srem;
    logic [31:0]        root;
    logic [31:0]        qrx;
    logic [31:0]        qry;
    logic [31:0]        qx;
    logic [31:0]        qy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [62:0]        tax;
    logic [62:0]        tay;
    logic signed [31:0] evx;
    logic signed [31:0] evy;
    logic               wsx;
    logic               wsy;
    logic [QW-1:0]      wx;
    logic [QW-1:0]      wy;
    logic [QL+30:0]     lox;
    logic [QL+30:0]     loy;
    logic [QH+30:0]     hix;
    logic [QH+30:0]     hiy;
    logic [PW-1:0]      pwx;
    logic [PW-1:0]      pwy;
    logic signed [31:0] epx;
    logic signed [31:0] epy;
  } item_t;

  logic [CFG_W-1:0] accel_limit_q, step_period_q, tick_time_q;
  logic [CFG_W-1:0] tick_eff, scale_mag;
  logic signed [32:0] scale;
  logic             scale_flip;
  logic             adv;
  logic [NS-1:0]    vld_q;
  item_t            pipe_q [NS];
  item_t            pipe_d [NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_limit_q <= ACCEL_LIMIT_RST;
      step_period_q <= STEP_PERIOD_RST;
      tick_time_q   <= TICK_TIME_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACCEL_LIMIT: accel_limit_q <= cfg_wdata_i;
        CFG_STEP_PERIOD: step_period_q <= cfg_wdata_i;
        CFG_TICK_TIME:   tick_time_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign tick_eff   = (tick_time_q == '0) ? CFG_W'(1) : tick_time_q;
  assign scale      = $signed({2'b00, accel_limit_q}) - 33'(EPS_Q);
  assign scale_flip = scale[32];
  assign scale_mag  = scale[32] ? CFG_W'(-scale) : scale[CFG_W-1:0];

  function automatic item_t prep(input logic op, input logic signed [31:0] px,
                                 input logic signed [31:0] py, input logic signed [31:0] vx,
                                 input logic signed [31:0] vy, input logic signed [31:0] tx,
                                 input logic signed [31:0] ty);
    item_t it;
    logic signed [32:0] dx, dy;
    logic signed [32:0] ndx, ndy;
    it = '0;
    it.op = op;
    it.px = px;
    it.py = py;
    it.vx = vx;
    it.vy = vy;
    dx = 33'(tx) - 33'(vx);
    dy = 33'(ty) - 33'(vy);
    ndx = -dx;
    ndy = -dy;
    if (op == OP_ACCEL) begin
      it.sx = tx[31];
      it.sy = ty[31];
      it.ux = NW'(mag32(tx));
      it.uy = NW'(mag32(ty));
    end else begin
      it.sx = dx[32];
      it.sy = dy[32];
      it.nx = {(dx[32] ? ndx[31:0] : dx[31:0]), {F{1'b0}}};
      it.ny = {(dy[32] ? ndy[31:0] : dy[31:0]), {F{1'b0}}};
    end
    return it;
  endfunction

  function automatic item_t div_step(input item_t i, input logic [CFG_W-1:0] tick);
    item_t it;
    logic [31:0] r;
    logic        ge;
    it = i;
    if (i.op == OP_CMD_VEL) begin
      r = {i.rx[30:0], i.nx[NW-1]};
      ge = r >= {1'b0, tick};
      if (ge) r = r - {1'b0, tick};
      it.rx = r;
      it.ux = {i.ux[NW-2:0], ge};
      it.nx = i.nx << 1;
      r = {i.ry[30:0], i.ny[NW-1]};
      ge = r >= {1'b0, tick};
      if (ge) r = r - {1'b0, tick};
      it.ry = r;
      it.uy = {i.uy[NW-2:0], ge};
      it.ny = i.ny << 1;
    end
    return it;
  endfunction

  function automatic item_t sq_step(input item_t i, input logic [CFG_W-1:0] lim);
    item_t it;
    it = i;
    it.big   = (i.ux[NW-1:31] != '0) || (i.uy[NW-1:31] != '0);
    it.sqx   = 62'(i.ux[30:0]) * 62'(i.ux[30:0]);
    it.sqy   = 62'(i.uy[30:0]) * 62'(i.uy[30:0]);
    it.limsq = 62'(lim) * 62'(lim);
    return it;
  endfunction

  function automatic item_t cmp_step(input item_t i);
    item_t it;
    it = i;
    it.capped = i.big || (({1'b0, i.sqx} + {1'b0, i.sqy}) > {1'b0, i.limsq});
    it.arx = i.sx ? -$signed(i.ux[31:0]) : $signed(i.ux[31:0]);
    it.ary = i.sy ? -$signed(i.uy[31:0]) : $signed(i.uy[31:0]);
    return it;
  endfunction

  function automatic item_t nrm_step(input item_t i, input int sh);
    item_t it;
    it = i;
    if (((i.ux | i.uy) >> (NW - sh)) == '0) begin
      it.ux = i.ux << sh;
      it.uy = i.uy << sh;
    end
    return it;
  endfunction

  function automatic item_t nsq_step(input item_t i, input logic [CFG_W-1:0] sm);
    item_t it;
    logic [30:0] mx, my;
    it = i;
    mx = i.ux[NW-1 -: 31];
    my = i.uy[NW-1 -: 31];
    it.sqx = 62'(mx) * 62'(mx);
    it.sqy = 62'(my) * 62'(my);
    it.pmx = 62'(mx) * 62'(sm);
    it.pmy = 62'(my) * 62'(sm);
    return it;
  endfunction

  function automatic item_t sum_step(input item_t i);
    item_t it;
    it = i;
    it.srem = 65'(i.sqx) + 65'(i.sqy);
    it.root = '0;
    it.qrx  = 32'(i.pmx[61:32]);
    it.qry  = 32'(i.pmy[61:32]);
    it.qx   = '0;
    it.qy   = '0;
    return it;
  endfunction

  function automatic item_t sqrt_step(input item_t i, input int b);
    item_t it;
    logic [64:0] cand;
    it = i;
    cand = (65'(i.root) << (b + 1)) + (65'(1) << (2 * b));
    if (i.srem >= cand) begin
      it.srem = i.srem - cand;
      it.root = i.root | (32'(1) << b);
    end
    return it;
  endfunction

  function automatic item_t qdiv_step(input item_t i, input int b);
    item_t it;
    logic [32:0] r;
    logic        ge;
    it = i;
    r = {i.qrx, i.pmx[b]};
    ge = r >= {1'b0, i.root};
    if (ge) r = r - {1'b0, i.root};
    it.qrx = r[31:0];
    it.qx = {i.qx[30:0], ge};
    r = {i.qry, i.pmy[b]};
    ge = r >= {1'b0, i.root};
    if (ge) r = r - {1'b0, i.root};
    it.qry = r[31:0];
    it.qy = {i.qy[30:0], ge};
    return it;
  endfunction

  function automatic item_t sel_step(input item_t i, input logic flip);
    item_t it;
    it = i;
    if (i.capped) begin
      it.ax = (i.sx ^ flip) ? -$signed(i.qx) : $signed(i.qx);
      it.ay = (i.sy ^ flip) ? -$signed(i.qy) : $signed(i.qy);
    end else begin
      it.ax = i.arx;
      it.ay = i.ary;
    end
    return it;
  endfunction

  function automatic item_t mt_step(input item_t i, input logic [CFG_W-1:0] t);
    item_t it;
    it = i;
    it.tax = 63'(mag32(i.ax)) * 63'(t);
    it.tay = 63'(mag32(i.ay)) * 63'(t);
    return it;
  endfunction

  function automatic item_t vr_step(input item_t i);
    item_t it;
    logic [RVW-1:0] rv, rh;
    logic signed [SAT_W-1:0] s, w;
    it = i;
    rv = RVW'(i.tax >> F) + RVW'(i.tax[F-1]);
    rh = RVW'(i.tax >> (F + 1)) + RVW'(i.tax[F]);
    s = SAT_W'($signed({1'b0, rv}));
    if (i.ax[31]) s = -s;
    it.evx = sat32(SAT_W'(i.vx) + s);
    s = SAT_W'($signed({1'b0, rh}));
    if (i.ax[31]) s = -s;
    w = SAT_W'(i.vx) + s;
    it.wsx = w[SAT_W-1];
    it.wx = w[SAT_W-1] ? QW'(-w) : QW'(w);
    rv = RVW'(i.tay >> F) + RVW'(i.tay[F-1]);
    rh = RVW'(i.tay >> (F + 1)) + RVW'(i.tay[F]);
    s = SAT_W'($signed({1'b0, rv}));
    if (i.ay[31]) s = -s;
    it.evy = sat32(SAT_W'(i.vy) + s);
    s = SAT_W'($signed({1'b0, rh}));
    if (i.ay[31]) s = -s;
    w = SAT_W'(i.vy) + s;
    it.wsy = w[SAT_W-1];
    it.wy = w[SAT_W-1] ? QW'(-w) : QW'(w);
    return it;
  endfunction

  function automatic item_t wm_step(input item_t i, input logic [CFG_W-1:0] t);
    item_t it;
    it = i;
    it.lox = (QL + 31)'(i.wx[QL-1:0]) * (QL + 31)'(t);
    it.hix = (QH + 31)'(i.wx[QW-1:QL]) * (QH + 31)'(t);
    it.loy = (QL + 31)'(i.wy[QL-1:0]) * (QL + 31)'(t);
    it.hiy = (QH + 31)'(i.wy[QW-1:QL]) * (QH + 31)'(t);
    return it;
  endfunction

  function automatic item_t wc_step(input item_t i);
    item_t it;
    it = i;
    it.pwx = (PW'(i.hix) << QL) + PW'(i.lox);
    it.pwy = (PW'(i.hiy) << QL) + PW'(i.loy);
    return it;
  endfunction

  function automatic item_t out_step(input item_t i);
    item_t it;
    logic [RW-1:0] r;
    logic signed [SAT_W-1:0] s;
    it = i;
    r = RW'(i.pwx >> F) + RW'(i.pwx[F-1]);
    s = SAT_W'($signed({1'b0, r}));
    if (i.wsx) s = -s;
    it.epx = sat32(SAT_W'(i.px) + s);
    r = RW'(i.pwy >> F) + RW'(i.pwy[F-1]);
    s = SAT_W'($signed({1'b0, r}));
    if (i.wsy) s = -s;
    it.epy = sat32(SAT_W'(i.py) + s);
    return it;
  endfunction

  assign pipe_d[I_IN] = prep(op_i, pos_x_i, pos_y_i, vel_x_i, vel_y_i, target_x_i, target_y_i);

  for (genvar k = 0; k < NW; k++) begin : g_div
    assign pipe_d[I_DIV0+k] = div_step(pipe_q[I_DIV0+k-1], tick_eff);
  end

  assign pipe_d[I_SQ]  = sq_step(pipe_q[I_SQ-1], accel_limit_q);
  assign pipe_d[I_CMP] = cmp_step(pipe_q[I_CMP-1]);

  for (genvar k = 0; k < NL; k++) begin : g_nrm
    assign pipe_d[I_NRM0+k] = nrm_step(pipe_q[I_NRM0+k-1], 1 << (NL - 1 - k));
  end

  assign pipe_d[I_NSQ] = nsq_step(pipe_q[I_NSQ-1], scale_mag);
  assign pipe_d[I_SUM] = sum_step(pipe_q[I_SUM-1]);

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    assign pipe_d[I_SQRT0+k] = sqrt_step(pipe_q[I_SQRT0+k-1], 31 - k);
  end

  for (genvar k = 0; k < 32; k++) begin : g_qdiv
    assign pipe_d[I_QDIV0+k] = qdiv_step(pipe_q[I_QDIV0+k-1], 31 - k);
  end

  assign pipe_d[I_SEL] = sel_step(pipe_q[I_SEL-1], scale_flip);
  assign pipe_d[I_MT]  = mt_step(pipe_q[I_MT-1], step_period_q);
  assign pipe_d[I_VR]  = vr_step(pipe_q[I_VR-1]);
  assign pipe_d[I_WM]  = wm_step(pipe_q[I_WM-1], step_period_q);
  assign pipe_d[I_WC]  = wc_step(pipe_q[I_WC-1]);
  assign pipe_d[I_OUT] = out_step(pipe_q[I_OUT-1]);

  // advance everything unless the finished beat is held
  assign adv        = !vld_q[NS-1] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q <= pipe_d;
    end
  end

  assign out_valid_o  = vld_q[NS-1];
  assign end_pos_x_o  = pipe_q[NS-1].epx;
  assign end_pos_y_o  = pipe_q[NS-1].epy;
  assign end_vel_x_o  = pipe_q[NS-1].evx;
  assign end_vel_y_o  = pipe_q[NS-1].evy;
  assign accel_x_o    = pipe_q[NS-1].ax;
  assign accel_y_o    = pipe_q[NS-1].ay;
  assign was_capped_o = pipe_q[NS-1].capped;

`ifndef SYNTH
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stall without a held result");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> vld_q == $past(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[I_QDIV0-1] && pipe_q[I_QDIV0-1].capped |-> pipe_q[I_QDIV0-1].root[31:30] != 2'b00)
    else $error("normalized norm below range");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[I_SEL-1] && pipe_q[I_SEL-1].capped |-> !pipe_q[I_SEL-1].qx[31] &&
    !pipe_q[I_SEL-1].qy[31])
    else $error("capped component exceeds limit");
`endif

endmodule
